### src/hbp_pkg.sv
// types, codes and name tables shared by the http request byte parser
`timescale 1ns / 1ps

package hbp_pkg;

   localparam int MethodCount  = 8;
   localparam int VersionCount = 7;
   localparam int NameLen      = 8;

   // one-hot parse phases
   typedef enum logic [12:0] {
      PH_METHOD  = 13'h0001,
      PH_PATH    = 13'h0002,
      PH_QKEY    = 13'h0004,
      PH_QVAL    = 13'h0008,
      PH_VERSION = 13'h0010,
      PH_VER_LF  = 13'h0020,
      PH_HSTART  = 13'h0040,
      PH_HNAME   = 13'h0080,
      PH_HSKIP   = 13'h0100,
      PH_HVALUE  = 13'h0200,
      PH_HLF     = 13'h0400,
      PH_ENDLF   = 13'h0800,
      PH_BODY    = 13'h1000
   } phase_type;

   typedef enum logic [3:0] {
      ROLE_METHOD  = 4'd0,
      ROLE_PATH    = 4'd1,
      ROLE_QKEY    = 4'd2,
      ROLE_QVAL    = 4'd3,
      ROLE_VERSION = 4'd4,
      ROLE_HNAME   = 4'd5,
      ROLE_HVALUE  = 4'd6,
      ROLE_BODY    = 4'd7,
      ROLE_DELIM   = 4'd8
   } role_type;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_METHOD_DONE  = 3'd1,
      EV_URL_DONE     = 3'd2,
      EV_VERSION_DONE = 3'd3,
      EV_LINE_DONE    = 3'd4,
      EV_HEADERS_DONE = 3'd5,
      EV_ERROR        = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      ERR_METHOD    = 3'd0,
      ERR_VERSION   = 3'd1,
      ERR_LINE_END  = 3'd2,
      ERR_NO_COLON  = 3'd3,
      ERR_TRUNCATED = 3'd4
   } error_type;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam logic [3:0] PosMax = 4'd15;

   localparam logic [7:0] METHOD_NAME [MethodCount][NameLen] = '{
      '{"G", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
      '{"P", "U", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
      '{"P", "O", "S", "T", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"D", "E", "L", "E", "T", "E", 8'h0, 8'h0},
      '{"P", "A", "T", "C", "H", 8'h0, 8'h0, 8'h0},
      '{"H", "E", "A", "D", 8'h0, 8'h0, 8'h0, 8'h0},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h0},
      '{"T", "R", "A", "C", "E", 8'h0, 8'h0, 8'h0}
   };
   localparam logic [3:0] METHOD_LEN [MethodCount] = '{
      4'd3, 4'd3, 4'd4, 4'd6, 4'd5, 4'd4, 4'd7, 4'd5
   };

   localparam logic [7:0] VERSION_NAME [VersionCount][NameLen] = '{
      '{"H", "T", "T", "P", "/", "1", ".", "0"},
      '{"H", "T", "T", "P", "/", "1", 8'h0, 8'h0},
      '{"H", "T", "T", "P", "/", "1", ".", "1"},
      '{"H", "T", "T", "P", "/", "2", 8'h0, 8'h0},
      '{"H", "T", "T", "P", "/", "2", ".", "0"},
      '{"H", "T", "T", "P", "/", "3", 8'h0, 8'h0},
      '{"H", "T", "T", "P", "/", "3", ".", "0"}
   };
   localparam logic [3:0] VERSION_LEN [VersionCount] = '{
      4'd8, 4'd6, 4'd8, 4'd6, 4'd8, 4'd6, 4'd8
   };
   localparam logic [1:0] VERSION_VAL [VersionCount] = '{
      2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
   };

   typedef struct packed {
      phase_type  phase;
      logic [3:0] pos;
      logic [7:0] mcand;
      logic [6:0] vcand;
      logic       err;
   } state_type;

   localparam state_type StateReset = '{
      phase: PH_METHOD, pos: 4'd0, mcand: 8'hff, vcand: 7'h7f, err: 1'b0
   };

   typedef struct packed {
      logic [7:0] out_byte;
      role_type   role;
      logic       pair_done;
      logic       key_dropped;
      event_type  event_res;
      logic [2:0] method_code;
      logic [1:0] version_code;
      error_type  error_code;
      logic       done_res;
   } result_type;

endpackage

### src/hbp_step.sv
// per-byte classifier: next parse state and result word for one byte
`timescale 1ns / 1ps

module hbp_step (
   input  hbp_pkg::state_type  cur,
   input  logic [7:0]          data_byte,
   input  logic                last,
   output hbp_pkg::state_type  nxt,
   output hbp_pkg::result_type res
);
   import hbp_pkg::*;

   logic       fail;
   error_type  fail_code;
   logic       m_found;
   logic [2:0] m_idx;
   logic [7:0] m_keep;
   logic       v_found;
   logic [1:0] v_val;
   logic [6:0] v_keep;

   // candidate narrowing and end-of-token lookup for method and version
   always_comb begin
      m_found = 1'b0;
      m_idx   = 3'd0;
      m_keep  = 8'h00;
      for (int i = MethodCount - 1; i >= 0; i--) begin
         if (cur.mcand[i] && METHOD_LEN[i] == cur.pos) begin
            m_found = 1'b1;
            m_idx   = 3'(i);
         end
         if (cur.mcand[i] && cur.pos < METHOD_LEN[i] && !cur.pos[3]
             && METHOD_NAME[i][cur.pos[2:0]] == data_byte) begin
            m_keep[i] = 1'b1;
         end
      end
      v_found = 1'b0;
      v_val   = 2'd0;
      v_keep  = 7'h00;
      for (int i = VersionCount - 1; i >= 0; i--) begin
         if (cur.vcand[i] && VERSION_LEN[i] == cur.pos) begin
            v_found = 1'b1;
            v_val   = VERSION_VAL[i];
         end
         if (cur.vcand[i] && cur.pos < VERSION_LEN[i] && !cur.pos[3]
             && VERSION_NAME[i][cur.pos[2:0]] == data_byte) begin
            v_keep[i] = 1'b1;
         end
      end
   end

   always_comb begin
      nxt       = cur;
      fail      = 1'b0;
      fail_code = ERR_LINE_END;
      res       = '0;
      res.out_byte   = data_byte;
      res.role       = ROLE_DELIM;
      res.event_res  = EV_NONE;
      res.error_code = ERR_METHOD;
      res.done_res   = last;

      if (!cur.err) begin
         unique case (cur.phase)
            PH_METHOD: begin
               if (data_byte == CH_SP) begin
                  if (m_found) begin
                     res.event_res   = EV_METHOD_DONE;
                     res.method_code = m_idx;
                     nxt.phase = PH_PATH;
                     nxt.pos   = 4'd0;
                     nxt.mcand = 8'hff;
                  end else begin
                     fail      = 1'b1;
                     fail_code = ERR_METHOD;
                  end
               end else begin
                  nxt.mcand = m_keep;
                  nxt.pos   = (cur.pos == PosMax) ? cur.pos : cur.pos + 4'd1;
                  res.role  = ROLE_METHOD;
               end
            end
            PH_PATH, PH_QKEY, PH_QVAL: begin
               if (data_byte == CH_SP) begin
                  res.key_dropped = (cur.phase == PH_QKEY) && (cur.pos != 4'd0);
                  res.pair_done   = (cur.phase == PH_QVAL);
                  res.event_res   = EV_URL_DONE;
                  nxt.phase = PH_VERSION;
                  nxt.pos   = 4'd0;
                  nxt.vcand = 7'h7f;
               end else if (cur.phase == PH_PATH) begin
                  if (data_byte == CH_QUEST) begin
                     nxt.phase = PH_QKEY;
                     nxt.pos   = 4'd0;
                  end else begin
                     res.role = ROLE_PATH;
                  end
               end else if (cur.phase == PH_QKEY) begin
                  // pos acts as a key-not-empty flag here
                  if (data_byte == CH_EQ) begin
                     nxt.phase = PH_QVAL;
                  end else if (data_byte == CH_AMP) begin
                     res.key_dropped = (cur.pos != 4'd0);
                     nxt.pos = 4'd0;
                  end else begin
                     res.role = ROLE_QKEY;
                     nxt.pos  = 4'd1;
                  end
               end else begin
                  if (data_byte == CH_AMP) begin
                     res.pair_done = 1'b1;
                     nxt.phase = PH_QKEY;
                     nxt.pos   = 4'd0;
                  end else begin
                     res.role = ROLE_QVAL;
                  end
               end
            end
            PH_VERSION: begin
               if (data_byte == CH_CR) begin
                  if (v_found) begin
                     res.event_res    = EV_VERSION_DONE;
                     res.version_code = v_val;
                     nxt.phase = PH_VER_LF;
                     nxt.pos   = 4'd0;
                  end else begin
                     fail      = 1'b1;
                     fail_code = ERR_VERSION;
                  end
               end else if (data_byte == CH_LF) begin
                  fail = 1'b1;
               end else begin
                  nxt.vcand = v_keep;
                  nxt.pos   = (cur.pos == PosMax) ? cur.pos : cur.pos + 4'd1;
                  res.role  = ROLE_VERSION;
               end
            end
            PH_VER_LF: begin
               if (data_byte == CH_LF) nxt.phase = PH_HSTART;
               else fail = 1'b1;
            end
            PH_HSTART, PH_HNAME: begin
               if (data_byte == CH_COLON) begin
                  nxt.phase = PH_HSKIP;
               end else if (cur.phase == PH_HSTART && data_byte == CH_CR) begin
                  nxt.phase = PH_ENDLF;
               end else if (cur.phase == PH_HSTART && data_byte == CH_LF) begin
                  fail = 1'b1;
               end else if (data_byte == CH_CR || data_byte == CH_LF) begin
                  fail      = 1'b1;
                  fail_code = ERR_NO_COLON;
               end else begin
                  res.role  = ROLE_HNAME;
                  nxt.phase = PH_HNAME;
               end
            end
            PH_HSKIP: begin
               if (data_byte == CH_CR) nxt.phase = PH_HLF;
               else if (data_byte == CH_LF) fail = 1'b1;
               else nxt.phase = PH_HVALUE;
            end
            PH_HVALUE: begin
               if (data_byte == CH_CR) nxt.phase = PH_HLF;
               else if (data_byte == CH_LF) fail = 1'b1;
               else res.role = ROLE_HVALUE;
            end
            PH_HLF: begin
               if (data_byte == CH_LF) begin
                  res.event_res = EV_LINE_DONE;
                  nxt.phase = PH_HSTART;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_ENDLF: begin
               if (data_byte == CH_LF) begin
                  res.event_res = EV_HEADERS_DONE;
                  nxt.phase = PH_BODY;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_BODY: begin
               res.role = ROLE_BODY;
            end
            default: begin
               fail = 1'b1;
            end
         endcase

         if (fail) begin
            res.role         = ROLE_DELIM;
            res.pair_done    = 1'b0;
            res.key_dropped  = 1'b0;
            res.method_code  = 3'd0;
            res.version_code = 2'd0;
            res.event_res    = EV_ERROR;
            res.error_code   = fail_code;
            nxt.err          = 1'b1;
         end else if (last && nxt.phase != PH_BODY) begin
            res.pair_done    = 1'b0;
            res.key_dropped  = 1'b0;
            res.method_code  = 3'd0;
            res.version_code = 2'd0;
            res.event_res    = EV_ERROR;
            res.error_code   = ERR_TRUNCATED;
         end
      end

      if (last) nxt = StateReset;
   end

endmodule

### src/http_request_byte_parser_top.sv
// top level: input register, byte classifier, result register
//
//   channel | ports                          | direction
//   req     | req_valid/req_stall, 2 fields  | in
//   rsp     | rsp_valid/rsp_stall, 9 fields  | out
//
// one result word per request word, one word per cycle sustained while rsp_stall is low
// words pass the input register, then the classifier into the result register
// parse state is updated when a word moves into the result register
// reset clears the valid flags and returns the parser to the method phase
// a stalled result holds; the input register fills behind it, then req_stall rises
`timescale 1ns / 1ps

module http_request_byte_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_role,
   output logic       rsp_pair_done,
   output logic       rsp_key_dropped,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_method_code,
   output logic [1:0] rsp_version_code,
   output logic [2:0] rsp_error_code,
   output logic       rsp_done_res
);
   import hbp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   state_type  state_ff, state_in;
   result_type step_res;
   logic       advance;
   logic       req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   hbp_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (advance) out_res_ff <= step_res;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_res_ff.out_byte;
   assign rsp_role         = out_res_ff.role;
   assign rsp_pair_done    = out_res_ff.pair_done;
   assign rsp_key_dropped  = out_res_ff.key_dropped;
   assign rsp_event_res    = out_res_ff.event_res;
   assign rsp_method_code  = out_res_ff.method_code;
   assign rsp_version_code = out_res_ff.version_code;
   assign rsp_error_code   = out_res_ff.error_code;
   assign rsp_done_res     = out_res_ff.done_res;

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.phase == PH_METHOD && !state_ff.err)
      else $error("last word did not return parser to method phase");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.err && !in_last_ff |=> state_ff.err)
      else $error("latched error cleared before last word");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parse state changed without a word moving");

   a_method_delim: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_event_res == EV_METHOD_DONE |-> rsp_role == ROLE_DELIM)
      else $error("method done on a non-delimiter word");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

### test/http_request_byte_parser_top_tb.sv
// self-checking testbench for the http request byte parser: directed table, then random requests
`timescale 1ns / 1ps

module http_request_byte_parser_top_tb;
   import hbp_pkg::*;

   localparam int StageItems  = 600;
   localparam int HoldCycles  = 64;
   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 8;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       fixed;
      result_type want;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_role;
   logic       rsp_pair_done;
   logic       rsp_key_dropped;
   logic [2:0] rsp_event_res;
   logic [2:0] rsp_method_code;
   logic [1:0] rsp_version_code;
   logic [2:0] rsp_error_code;
   logic       rsp_done_res;

   string method_names [MethodCount] = '{
      "GET", "PUT", "POST", "DELETE", "PATCH", "HEAD", "OPTIONS", "TRACE"
   };
   string version_names [VersionCount] = '{
      "HTTP/1.0", "HTTP/1", "HTTP/1.1", "HTTP/2", "HTTP/2.0", "HTTP/3", "HTTP/3.0"
   };
   logic [1:0] version_codes [VersionCount] = '{
      2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
   };

   // parser state as the byte stream should leave it
   phase_type  parse_phase;
   logic [3:0] match_pos;
   logic [7:0] method_mask;
   logic [6:0] version_mask;
   logic       error_held;

   result_type   expected_words [$];
   stim_row_type directed_rows [$];
   logic [7:0]   req_bytes [$];
   result_type   head_word;

   int sender_idle;
   int receiver_idle;
   int mismatches = 0;
   int quiet_cycles = 0;
   int hold_count = 0;
   logic hold_req;

   http_request_byte_parser_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_role         (rsp_role),
      .rsp_pair_done    (rsp_pair_done),
      .rsp_key_dropped  (rsp_key_dropped),
      .rsp_event_res    (rsp_event_res),
      .rsp_method_code  (rsp_method_code),
      .rsp_version_code (rsp_version_code),
      .rsp_error_code   (rsp_error_code),
      .rsp_done_res     (rsp_done_res)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic void restart_parse();
      parse_phase  = PH_METHOD;
      match_pos    = 4'd0;
      method_mask  = 8'hff;
      version_mask = 7'h7f;
      error_held   = 1'b0;
   endfunction

   function automatic result_type classify_byte(input logic [7:0] b, input logic last);
      result_type r;
      logic [7:0] keep_m;
      logic [6:0] keep_v;
      int         hit;
      logic       failed;
      error_type  why;
      r          = '0;
      r.out_byte = b;
      r.role     = ROLE_DELIM;
      r.done_res = last;
      keep_m     = '0;
      keep_v     = '0;
      hit        = -1;
      failed     = 1'b0;
      why        = ERR_METHOD;
      if (!error_held) begin
         case (parse_phase)
            PH_METHOD: begin
               if (b == CH_SP) begin
                  // first surviving name of exactly the typed length wins
                  for (int i = MethodCount - 1; i >= 0; i--)
                     if (method_mask[i] && method_names[i].len() == match_pos) hit = i;
                  if (hit >= 0) begin
                     r.event_res   = EV_METHOD_DONE;
                     r.method_code = hit[2:0];
                     parse_phase   = PH_PATH;
                     match_pos     = 4'd0;
                     method_mask   = 8'hff;
                  end else begin
                     failed = 1'b1;
                     why    = ERR_METHOD;
                  end
               end else begin
                  for (int i = 0; i < MethodCount; i++)
                     if (method_mask[i] && match_pos < method_names[i].len()
                         && method_names[i][match_pos] == b) keep_m[i] = 1'b1;
                  method_mask = keep_m;
                  if (match_pos != PosMax) match_pos++;
                  r.role = ROLE_METHOD;
               end
            end
            PH_PATH, PH_QKEY, PH_QVAL: begin
               if (b == CH_SP) begin
                  r.key_dropped = (parse_phase == PH_QKEY) && (match_pos != 4'd0);
                  r.pair_done   = (parse_phase == PH_QVAL);
                  r.event_res   = EV_URL_DONE;
                  parse_phase   = PH_VERSION;
                  match_pos     = 4'd0;
                  version_mask  = 7'h7f;
               end else if (parse_phase == PH_PATH) begin
                  if (b == CH_QUEST) begin
                     parse_phase = PH_QKEY;
                     match_pos   = 4'd0;
                  end else
                     r.role = ROLE_PATH;
               end else if (parse_phase == PH_QKEY) begin
                  // match_pos flags a key with at least one byte
                  if (b == CH_EQ)
                     parse_phase = PH_QVAL;
                  else if (b == CH_AMP) begin
                     r.key_dropped = (match_pos != 4'd0);
                     match_pos     = 4'd0;
                  end else begin
                     r.role    = ROLE_QKEY;
                     match_pos = 4'd1;
                  end
               end else begin
                  if (b == CH_AMP) begin
                     r.pair_done = 1'b1;
                     parse_phase = PH_QKEY;
                     match_pos   = 4'd0;
                  end else
                     r.role = ROLE_QVAL;
               end
            end
            PH_VERSION: begin
               if (b == CH_CR) begin
                  for (int i = VersionCount - 1; i >= 0; i--)
                     if (version_mask[i] && version_names[i].len() == match_pos) hit = i;
                  if (hit >= 0) begin
                     r.event_res    = EV_VERSION_DONE;
                     r.version_code = version_codes[hit];
                     parse_phase    = PH_VER_LF;
                     match_pos      = 4'd0;
                  end else begin
                     failed = 1'b1;
                     why    = ERR_VERSION;
                  end
               end else if (b == CH_LF) begin
                  failed = 1'b1;
                  why    = ERR_LINE_END;
               end else begin
                  for (int i = 0; i < VersionCount; i++)
                     if (version_mask[i] && match_pos < version_names[i].len()
                         && version_names[i][match_pos] == b) keep_v[i] = 1'b1;
                  version_mask = keep_v;
                  if (match_pos != PosMax) match_pos++;
                  r.role = ROLE_VERSION;
               end
            end
            PH_VER_LF: begin
               if (b == CH_LF)
                  parse_phase = PH_HSTART;
               else begin
                  failed = 1'b1;
                  why    = ERR_LINE_END;
               end
            end
            PH_HSTART, PH_HNAME: begin
               if (b == CH_COLON)
                  parse_phase = PH_HSKIP;
               else if (parse_phase == PH_HSTART && b == CH_CR)
                  parse_phase = PH_ENDLF;
               else if (parse_phase == PH_HSTART && b == CH_LF) begin
                  failed = 1'b1;
                  why    = ERR_LINE_END;
               end else if (b == CH_CR || b == CH_LF) begin
                  failed = 1'b1;
                  why    = ERR_NO_COLON;
               end else begin
                  r.role      = ROLE_HNAME;
                  parse_phase = PH_HNAME;
               end
            end
            PH_HSKIP, PH_HVALUE: begin
               if (b == CH_CR)
                  parse_phase = PH_HLF;
               else if (b == CH_LF) begin
                  failed = 1'b1;
                  why    = ERR_LINE_END;
               end else if (parse_phase == PH_HSKIP)
                  parse_phase = PH_HVALUE;
               else
                  r.role = ROLE_HVALUE;
            end
            PH_HLF, PH_ENDLF: begin
               if (b == CH_LF) begin
                  r.event_res = (parse_phase == PH_HLF) ? EV_LINE_DONE : EV_HEADERS_DONE;
                  parse_phase = (parse_phase == PH_HLF) ? PH_HSTART : PH_BODY;
               end else begin
                  failed = 1'b1;
                  why    = ERR_LINE_END;
               end
            end
            PH_BODY: r.role = ROLE_BODY;
            default: begin
               failed = 1'b1;
               why    = ERR_LINE_END;
            end
         endcase
         if (failed) begin
            r              = '0;
            r.out_byte     = b;
            r.role         = ROLE_DELIM;
            r.done_res     = last;
            r.event_res    = EV_ERROR;
            r.error_code   = why;
            error_held     = 1'b1;
         end else if (last && parse_phase != PH_BODY) begin
            // truncation keeps the role, byte and done flag but replaces the other fields
            r.pair_done    = 1'b0;
            r.key_dropped  = 1'b0;
            r.method_code  = 3'd0;
            r.version_code = 2'd0;
            r.event_res    = EV_ERROR;
            r.error_code   = ERR_TRUNCATED;
         end
      end
      if (last) restart_parse();
      return r;
   endfunction

   function automatic result_type known(input logic [7:0] b, input logic last,
                                        input role_type role, input event_type ev,
                                        input error_type code);
      result_type r;
      r            = '0;
      r.out_byte   = b;
      r.role       = role;
      r.event_res  = ev;
      r.error_code = code;
      r.done_res   = last;
      return r;
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // printable, never space
   function automatic logic [7:0] text_byte();
      return 8'($urandom_range(33, 126));
   endfunction

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
   endtask

   task automatic add_line_end();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 95) begin
         req_bytes.push_back(CH_CR);
         req_bytes.push_back(CH_LF);
      end else if (pick < 97)
         req_bytes.push_back(CH_LF);
      else begin
         req_bytes.push_back(CH_CR);
         req_bytes.push_back(text_byte());
      end
   endtask

   task automatic build_request();
      int         pick;
      int         cut;
      logic [7:0] c;
      string      m;
      req_bytes.delete();
      if ($urandom_range(0, 99) < 5) begin
         repeat ($urandom_range(1, 12)) req_bytes.push_back(any_byte());
         return;
      end
      // method: mostly a real name, else a near miss, an overlong token or nothing
      m    = method_names[$urandom_range(0, MethodCount - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 84)
         append_text(m);
      else if (pick < 90)
         append_text(m.substr(0, m.len() - 2));
      else if (pick < 94) begin
         append_text(m);
         req_bytes.push_back(text_byte());
      end else if (pick < 97)
         repeat ($urandom_range(14, 20)) req_bytes.push_back(text_byte());
      req_bytes.push_back(CH_SP);
      repeat ($urandom_range(0, 12)) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            c = CH_QUEST;
         else if (pick < 30)
            c = CH_EQ;
         else if (pick < 45)
            c = CH_AMP;
         else if (pick < 92)
            c = text_byte();
         else begin
            c = any_byte();
            if (c == CH_SP) c = "_";
         end
         req_bytes.push_back(c);
      end
      req_bytes.push_back(CH_SP);
      m    = version_names[$urandom_range(0, VersionCount - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 86)
         append_text(m);
      else if (pick < 92)
         append_text(m.substr(0, m.len() - 2));
      else if (pick < 96) begin
         append_text("HTTP/");
         req_bytes.push_back(text_byte());
      end else
         repeat ($urandom_range(0, 17)) req_bytes.push_back(text_byte());
      add_line_end();
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(0, 6)) begin
            c = text_byte();
            if (c == CH_COLON) c = "-";
            req_bytes.push_back(c);
         end
         if ($urandom_range(0, 99) < 95) begin
            req_bytes.push_back(CH_COLON);
            // byte after the colon: usually a space, else a text byte, an LF, or missing so CR lands there
            pick = $urandom_range(0, 99);
            if (pick < 80)
               req_bytes.push_back(CH_SP);
            else if (pick < 90)
               req_bytes.push_back(text_byte());
            else if (pick < 94)
               req_bytes.push_back(CH_LF);
            if (pick < 90)
               repeat ($urandom_range(0, 8)) begin
                  c = any_byte();
                  if (c == CH_CR || c == CH_LF) c = "v";
                  req_bytes.push_back(c);
               end
         end
         add_line_end();
      end
      add_line_end();
      repeat ($urandom_range(0, 8)) req_bytes.push_back(any_byte());
      if ($urandom_range(0, 99) < 12) begin
         cut = $urandom_range(1, req_bytes.size());
         while (req_bytes.size() > cut) void'(req_bytes.pop_back());
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic fixed, input result_type want);
      result_type guess;
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
      guess = classify_byte(b, last);
      expected_words.push_back(fixed ? want : guess);
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
      end
   endtask

   always @(negedge clock) begin
      if (hold_req && hold_count < HoldCycles) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            $error("unexpected result word, out_byte %0d", rsp_out_byte);
         end else begin
            head_word = expected_words.pop_front();
            check_field("out_byte", head_word.out_byte, rsp_out_byte);
            check_field("role", head_word.role, rsp_role);
            check_field("pair_done", head_word.pair_done, rsp_pair_done);
            check_field("key_dropped", head_word.key_dropped, rsp_key_dropped);
            check_field("event_res", head_word.event_res, rsp_event_res);
            check_field("method_code", head_word.method_code, rsp_method_code);
            check_field("version_code", head_word.version_code, rsp_version_code);
            check_field("error_code", head_word.error_code, rsp_error_code);
            check_field("done_res", head_word.done_res, rsp_done_res);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("http_request_byte_parser_top_tb: errors");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last      = 1'b0;
      hold_req      = 1'b0;
      sender_idle   = 18;
      receiver_idle = 82;
      restart_parse();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-byte requests, empty method, latched error up to the last byte
      directed_rows.push_back('{8'h00, 1'b1, 1'b1,
         known(8'h00, 1'b1, ROLE_METHOD, EV_ERROR, ERR_TRUNCATED)});
      directed_rows.push_back('{CH_SP, 1'b1, 1'b1,
         known(CH_SP, 1'b1, ROLE_DELIM, EV_ERROR, ERR_METHOD)});
      directed_rows.push_back('{"X", 1'b0, 1'b0, '0});
      directed_rows.push_back('{CH_SP, 1'b0, 1'b1,
         known(CH_SP, 1'b0, ROLE_DELIM, EV_ERROR, ERR_METHOD)});
      directed_rows.push_back('{8'hff, 1'b1, 1'b1,
         known(8'hff, 1'b1, ROLE_DELIM, EV_NONE, ERR_METHOD)});
      // empty key pair, dropped key, empty header name with empty value, body
      req_bytes.delete();
      append_text("GET ?=&k HTTP/3");
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
      req_bytes.push_back(CH_COLON);
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
      req_bytes.push_back(8'h80);
      foreach (req_bytes[i])
         directed_rows.push_back('{req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0});
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].fixed, directed_rows[i].want);

      for (int stage = 0; stage < 3; stage++) begin
         int sent;
         sent          = 0;
         sender_idle   = (stage == 0) ? 18 : (stage == 1) ? 82 : 0;
         receiver_idle = (stage == 0) ? 82 : (stage == 1) ? 18 : 0;
         // long receiver hold while the sender keeps going
         if (stage == 2) hold_req <= 1'b1;
         while (sent < StageItems) begin
            build_request();
            for (int i = 0; i < req_bytes.size(); i++)
               send_byte(req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0);
            sent += req_bytes.size();
         end
      end
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("http_request_byte_parser_top_tb: clean");
      else
         $display("http_request_byte_parser_top_tb: errors");
      $finish;
   end

endmodule

### sim.f
src/hbp_pkg.sv
src/hbp_step.sv
src/http_request_byte_parser_top.sv
test/http_request_byte_parser_top_tb.sv
